// ----- src/pfrf_pkg.sv -----
// Shared types, constants and the page mask helper for the paged framebuffer
// rectangle fill unit. No dependencies; imported by every module of the block.
package pfrf_pkg;

   localparam int unsigned COL_MAX_W  = 8;   // enough for up to 256 columns
   localparam int unsigned PAGE_MAX_W = 5;   // enough for up to 32 pages
   localparam int unsigned COORD_W    = 9;   // room for coordinate plus extent
   localparam logic [7:0]  BYTE_ONES  = 8'hFF;
   localparam logic [7:0]  BYTE_ZERO  = 8'h00;

   typedef enum logic [1:0] {
      MODE_DOT    = 2'd0,
      MODE_FILL   = 2'd1,
      MODE_INVERT = 2'd2,
      MODE_READ   = 2'd3
   } req_mode_type;

   typedef enum logic [1:0] {
      OP_SET,
      OP_CLEAR,
      OP_INVERT,
      OP_READ
   } cmd_op_type;

   typedef struct packed {
      cmd_op_type              op;
      logic                    on_screen;
      logic [COL_MAX_W-1:0]    col_first;
      logic [COL_MAX_W-1:0]    col_last;
      logic [PAGE_MAX_W-1:0]   page_first;
      logic [PAGE_MAX_W-1:0]   page_last;
      logic [2:0]              row_lo;
      logic [2:0]              row_hi;
   } cmd_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_RD,
      ST_WR,
      ST_FETCH,
      ST_RESP
   } back_state_type;

   // Rows lo..hi of one page, bit 0 being the top row.
   function automatic logic [7:0] page_mask(input logic [2:0] lo, input logic [2:0] hi);
      return (BYTE_ONES << lo) & (BYTE_ONES >> (3'd7 - hi));
   endfunction

endpackage

// ----- src/pfrf_front.sv -----
// Front end: accepts command items, clips them to the display and turns them
// into descriptors for the command queue. Depends on pfrf_pkg.
module pfrf_front #(
   parameter int unsigned COLUMNS = 128,
   parameter int unsigned ROWS    = 64
) (
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [31:0]      req_tdata,  // x[6:0], y[12:7], width[19:13], height[25:20], color[26]
   input  logic [1:0]       req_tuser,  // mode[1:0]
   input  logic             clearing,
   input  logic             q_full,
   output logic             push,
   output pfrf_pkg::cmd_type push_cmd
);
   import pfrf_pkg::*;

   logic [6:0]         x;
   logic [5:0]         y;
   logic [6:0]         width;
   logic [5:0]         height;
   logic               color;
   req_mode_type       mode;
   logic [COORD_W-1:0] x_ext, y_ext, x_sum, y_sum, x_last, y_last;
   logic [COORD_W-1:0] col_lim, row_lim;
   logic               on_screen;

   assign x      = req_tdata[6:0];
   assign y      = req_tdata[12:7];
   assign width  = req_tdata[19:13];
   assign height = req_tdata[25:20];
   assign color  = req_tdata[26];
   assign mode   = req_mode_type'(req_tuser);

   assign req_tready = !q_full && !clearing;
   assign push       = req_tvalid && req_tready;

   always_comb begin
      x_ext     = COORD_W'(x);
      y_ext     = COORD_W'(y);
      col_lim   = COORD_W'(COLUMNS - 1);
      row_lim   = COORD_W'(ROWS - 1);
      on_screen = (x_ext < COORD_W'(COLUMNS)) && (y_ext < COORD_W'(ROWS));
      // a dot is a one-pixel rectangle
      if (mode == MODE_DOT) begin
         x_sum = x_ext;
         y_sum = y_ext;
      end else begin
         x_sum = x_ext + COORD_W'(width);
         y_sum = y_ext + COORD_W'(height);
      end
      x_last = (x_sum > col_lim) ? col_lim : x_sum;
      y_last = (y_sum > row_lim) ? row_lim : y_sum;

      push_cmd.on_screen  = on_screen;
      push_cmd.col_first  = x_ext[COL_MAX_W-1:0];
      push_cmd.col_last   = x_last[COL_MAX_W-1:0];
      push_cmd.page_first = y_ext[PAGE_MAX_W+2:3];
      push_cmd.page_last  = y_last[PAGE_MAX_W+2:3];
      push_cmd.row_lo     = y_ext[2:0];
      push_cmd.row_hi     = y_last[2:0];

      unique case (mode) inside
         MODE_DOT, MODE_FILL: push_cmd.op = color ? OP_SET : OP_CLEAR;
         MODE_INVERT:         push_cmd.op = OP_INVERT;
         default:             push_cmd.op = OP_READ;
      endcase
      // outside the display nothing changes: only the read-back remains
      if (!on_screen) begin
         push_cmd.op = OP_READ;
      end
   end

endmodule

// ----- src/pfrf_queue.sv -----
// Two-entry command queue between the front end and the drawing engine.
// Depends on pfrf_pkg for the descriptor type.
module pfrf_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  pfrf_pkg::cmd_type push_cmd,
   output logic              q_full,
   input  logic              pop,
   output logic              q_valid,
   output pfrf_pkg::cmd_type head_cmd
);
   import pfrf_pkg::*;

   cmd_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign q_full   = (count_ff == 2'd2);
   assign q_valid  = (count_ff != 2'd0);
   assign head_cmd = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ----- src/pfrf_back.sv -----
// Drawing engine: owns the display memory, clears it after reset, walks each
// rectangle one byte at a time and returns the read-back byte. Depends on pfrf_pkg.
module pfrf_back #(
   parameter int unsigned COLUMNS = 128,
   parameter int unsigned ROWS    = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  pfrf_pkg::cmd_type head_cmd,
   output logic              pop,
   output logic              clearing,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [7:0]        rsp_tdata
);
   import pfrf_pkg::*;

   localparam int unsigned PAGES = (ROWS + 7) / 8;
   localparam int unsigned DEPTH = PAGES * COLUMNS;
   localparam int unsigned CW    = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
   localparam int unsigned PW    = (PAGES > 1) ? $clog2(PAGES) : 1;
   localparam int unsigned AW    = $clog2(DEPTH);

   logic [7:0]     ram [DEPTH];

   back_state_type state_ff, state_in;
   cmd_type        cmd_ff, cmd_in;
   logic [CW-1:0]  col_ff, col_in;
   logic [PW-1:0]  page_ff, page_in;
   logic [AW-1:0]  clr_ff, clr_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [7:0]     rsp_data_ff, rsp_data_in;
   logic [7:0]     rd_data_ff;

   logic [AW-1:0]  cur_addr, fetch_addr, rd_addr, wr_addr;
   logic           wr_en;
   logic [7:0]     wr_data, rmw_data, mask;
   logic [2:0]     lo, hi;
   logic           col_end, page_end;

   assign cur_addr   = AW'(page_ff) * AW'(COLUMNS) + AW'(col_ff);
   assign fetch_addr = AW'(cmd_ff.page_first[PW-1:0]) * AW'(COLUMNS)
                       + AW'(cmd_ff.col_first[CW-1:0]);
   assign col_end    = (col_ff == cmd_ff.col_last[CW-1:0]);
   assign page_end   = (page_ff == cmd_ff.page_last[PW-1:0]);

   assign clearing   = (state_ff == ST_CLEAR);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      lo   = (page_ff == cmd_ff.page_first[PW-1:0]) ? cmd_ff.row_lo : 3'd0;
      hi   = page_end ? cmd_ff.row_hi : 3'd7;
      mask = page_mask(lo, hi);
      case (cmd_ff.op)
         OP_SET:    rmw_data = rd_data_ff | mask;
         OP_CLEAR:  rmw_data = rd_data_ff & ~mask;
         OP_INVERT: rmw_data = rd_data_ff ^ mask;
         default:   rmw_data = rd_data_ff;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      col_in       = col_ff;
      page_in      = page_ff;
      clr_in       = clr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      pop          = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = cur_addr;
      wr_data      = rmw_data;
      rd_addr      = cur_addr;

      unique case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = BYTE_ZERO;
            clr_in  = clr_ff + AW'(1);
            if (clr_ff == AW'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (q_valid) begin
               pop     = 1'b1;
               cmd_in  = head_cmd;
               col_in  = head_cmd.col_first[CW-1:0];
               page_in = head_cmd.page_first[PW-1:0];
               state_in = (head_cmd.op == OP_READ) ? ST_FETCH : ST_RD;
            end
         end
         ST_RD: begin
            state_in = ST_WR;
         end
         ST_WR: begin
            wr_en = 1'b1;
            if (col_end) begin
               col_in = cmd_ff.col_first[CW-1:0];
               if (page_end) begin
                  state_in = ST_FETCH;
               end else begin
                  page_in  = page_ff + PW'(1);
                  state_in = ST_RD;
               end
            end else begin
               col_in   = col_ff + CW'(1);
               state_in = ST_RD;
            end
         end
         ST_FETCH: begin
            rd_addr  = fetch_addr;
            state_in = ST_RESP;
         end
         ST_RESP: begin
            // hold the fetch address so the read data stays put while stalled
            rd_addr = fetch_addr;
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = cmd_ff.on_screen ? rd_data_ff : BYTE_ZERO;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      col_ff      <= col_in;
      page_ff     <= page_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         ram[wr_addr] <= wr_data;
      end
      rd_data_ff <= ram[rd_addr];
   end

`ifndef SYNTHESIS
   a_no_pop_while_clearing: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CLEAR |-> !pop)
      else $error("command taken during memory clear");

   a_rsp_only_from_resp: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_RESP))
      else $error("result raised outside the response step");

   a_walk_in_bounds: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WR |-> (page_ff <= cmd_ff.page_last[PW-1:0])
                            && (col_ff <= cmd_ff.col_last[CW-1:0]))
      else $error("rectangle walk left its bounds");

   a_rmw_pairs: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WR |-> $past(state_ff == ST_RD))
      else $error("byte write without its read");
`endif

endmodule

// ----- src/paged_framebuffer_rect_fill_unit.sv -----
// Paged monochrome framebuffer with dot, rectangle fill/invert and byte read.
// A read or an off-screen command goes straight to the fetch and response steps;
// a rectangle first reads then writes each display byte it covers.
// The memory walk sets the command rate; the two-entry queue takes new commands while
// one is drawn. Reset: synchronous; a clear pass over PAGES*COLUMNS bytes (1024 by default)
// zeroes the memory, and no item is taken until it ends.
module paged_framebuffer_rect_fill_unit #(
   parameter int unsigned COLUMNS = 128,
   parameter int unsigned ROWS    = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // x[6:0], y[12:7], width[19:13], height[25:20], color[26]
   input  logic [1:0]  req_tuser,  // mode[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata   // read_data[7:0]
);
   import pfrf_pkg::*;

   logic    push, pop, q_full, q_valid, clearing;
   cmd_type push_cmd, head_cmd;

   pfrf_front #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .clearing   (clearing),
      .q_full     (q_full),
      .push       (push),
      .push_cmd   (push_cmd)
   );

   pfrf_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .q_full   (q_full),
      .pop      (pop),
      .q_valid  (q_valid),
      .head_cmd (head_cmd)
   );

   pfrf_back #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .head_cmd   (head_cmd),
      .pop        (pop),
      .clearing   (clearing),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// ----- sim/tb_top.sv -----
// Self-checking bench for the paged framebuffer rectangle fill unit: directed table, then
// random commands scored against a local model of the display memory.
// Depends on pfrf_pkg (mode codes) and paged_framebuffer_rect_fill_unit.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import pfrf_pkg::*;

   localparam int COLUMNS      = 128;
   localparam int ROWS         = 64;
   localparam int PAGES        = (ROWS + 7) / 8;
   localparam int N_RANDOM     = 556;
   localparam int SQUEEZE_FROM = 200;    // random index where the receiver starts holding off
   localparam int SQUEEZE_LEN  = 40;
   localparam int HOLD_CYCLES  = 400;
   localparam int IDLE_LIMIT   = 20000;
   localparam int DRAIN_CYCLES = 16;

   typedef struct {
      req_mode_type mode;
      logic [6:0]   x;
      logic [5:0]   y;
      logic [6:0]   w;
      logic [5:0]   h;
      logic         color;
   } fb_cmd_type;

   typedef struct {
      fb_cmd_type cmd;
      bit         typed;
      logic [7:0] byte_val;
   } fb_row_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;
   logic [1:0]  req_tuser  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;

   logic [7:0]  fb_mem [0:PAGES*COLUMNS-1];
   logic [7:0]  read_data_due [$];
   fb_row_type  directed_rows [$];

   int cmds_taken    = 0;
   int bytes_checked = 0;
   int err_cnt       = 0;
   int burst_left    = 0;
   int idle_cycles   = 0;
   int mode_cnt [4]  = '{0, 0, 0, 0};

   paged_framebuffer_rect_fill_unit #(.COLUMNS(COLUMNS), .ROWS(ROWS)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #2 clock = ~clock;

   // Apply one command to the local display copy and return the byte at x, page y/8.
   function automatic logic [7:0] fb_execute(input fb_cmd_type c);
      int         xl;
      int         yl;
      int         p;
      int         col;
      int         lo;
      int         hi;
      int         b;
      logic [7:0] m;
      case (c.mode)
         MODE_DOT: begin
            fb_mem[(c.y / 8) * COLUMNS + c.x][c.y % 8] = c.color;
         end
         MODE_FILL, MODE_INVERT: begin
            xl = c.x + c.w;
            yl = c.y + c.h;
            if (xl > COLUMNS - 1) xl = COLUMNS - 1;
            if (yl > ROWS - 1) yl = ROWS - 1;
            for (p = c.y / 8; p <= yl / 8; p++) begin
               lo = (p == c.y / 8) ? c.y % 8 : 0;
               hi = (p == yl / 8) ? yl % 8 : 7;
               for (b = 0; b < 8; b++) m[b] = (b >= lo) && (b <= hi);
               for (col = c.x; col <= xl; col++) begin
                  if (c.mode == MODE_INVERT)
                     fb_mem[p * COLUMNS + col] ^= m;
                  else if (c.color)
                     fb_mem[p * COLUMNS + col] |= m;
                  else
                     fb_mem[p * COLUMNS + col] &= ~m;
               end
            end
         end
         default: ;
      endcase
      return fb_mem[(c.y / 8) * COLUMNS + c.x];
   endfunction

   function automatic void add_row(input req_mode_type mode, input int x, input int y,
                                   input int w, input int h, input bit color,
                                   input bit typed, input logic [7:0] byte_val);
      fb_row_type r;
      r.cmd.mode  = mode;
      r.cmd.x     = x[6:0];
      r.cmd.y     = y[5:0];
      r.cmd.w     = w[6:0];
      r.cmd.h     = h[5:0];
      r.cmd.color = color;
      r.typed     = typed;
      r.byte_val  = byte_val;
      directed_rows.push_back(r);
   endfunction

   function automatic fb_cmd_type random_cmd();
      fb_cmd_type c;
      int         size_pick;
      c.mode    = req_mode_type'($urandom_range(0, 3));
      c.x       = 7'($urandom_range(0, 127));
      c.y       = 6'($urandom_range(0, 63));
      c.color   = 1'($urandom_range(0, 1));
      size_pick = $urandom_range(0, 99);
      // keep most rectangles small; a full-screen walk visits every byte of the display
      if (size_pick < 85) begin
         c.w = 7'($urandom_range(0, 7));
         c.h = 6'($urandom_range(0, 11));
      end else if (size_pick < 95) begin
         c.w = 7'($urandom_range(0, 40));
         c.h = 6'($urandom_range(0, 30));
      end else begin
         c.w = 7'($urandom_range(0, 127));
         c.h = 6'($urandom_range(0, 63));
      end
      return c;
   endfunction

   // Offer one command, hold it until taken, and queue the byte it should return.
   task automatic send_cmd(input fb_cmd_type c, input bit typed, input logic [7:0] byte_val,
                           input bit no_gap);
      int         gap;
      bit         taken;
      logic [7:0] predicted;
      gap   = 0;
      taken = 0;
      if (!no_gap) begin
         if (burst_left == 0) begin
            gap        = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
                                                     : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 12);
         end else begin
            burst_left--;
         end
      end
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {5'b0, c.color, c.h, c.w, c.y, c.x};
      req_tuser  <= c.mode;
      while (!taken) begin
         @(negedge clock);
         if (req_tready) begin
            taken     = 1;
            predicted = fb_execute(c);
            read_data_due.push_back(typed ? byte_val : predicted);
            mode_cnt[c.mode]++;
            cmds_taken++;
         end
         @(posedge clock);
      end
   endtask

   // Receiver: changing stall pattern, plus one long hold-off to back the block up.
   always @(posedge clock) begin : rsp_side
      static int  hold_left  = 0;
      static bit  hold_done  = 0;
      static int  style      = 0;
      static int  style_left = 0;
      static int  cyc        = 0;
      cyc++;
      if (style_left == 0) begin
         style      = $urandom_range(0, 3);
         style_left = $urandom_range(64, 256);
      end else begin
         style_left--;
      end
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left--;
      end else if (!hold_done && cmds_taken >= directed_rows.size() + SQUEEZE_FROM) begin
         hold_done = 1;
         hold_left = HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else begin
         case (style)
            0:       rsp_tready <= 1'b1;
            1:       rsp_tready <= 1'($urandom_range(0, 1));
            2:       rsp_tready <= ($urandom_range(0, 3) == 0);
            default: rsp_tready <= (cyc % 8) > 2;
         endcase
      end
   end

   // Score results and watch for a stall; sampled mid-cycle, away from the driving edge.
   always @(negedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (read_data_due.size() == 0) begin
            $error("read_data: result %02h arrived with no command outstanding", rsp_tdata);
            err_cnt++;
         end else begin
            if (rsp_tdata !== read_data_due[0]) begin
               $error("read_data mismatch: expected %02h, actual %02h",
                      read_data_due[0], rsp_tdata);
               err_cnt++;
            end
            void'(read_data_due.pop_front());
            bytes_checked++;
         end
      end
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Timeout: no item moved for %0d cycles", IDLE_LIMIT);
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin : stimulus
      fb_cmd_type c;
      int         i;
      for (i = 0; i < PAGES * COLUMNS; i++) fb_mem[i] = 8'h00;

      add_row(MODE_READ,     0,  0,   0,  0, 1'b0, 1, 8'h00);
      add_row(MODE_READ,   127, 63,   0,  0, 1'b1, 1, 8'h00);
      add_row(MODE_DOT,      0,  0,   0,  0, 1'b1, 1, 8'h01);
      add_row(MODE_DOT,    127, 63, 127, 63, 1'b1, 1, 8'h80);
      add_row(MODE_DOT,      0,  0,   0,  0, 1'b0, 1, 8'h00);
      add_row(MODE_FILL,     0,  0, 127, 63, 1'b1, 1, 8'hFF);
      add_row(MODE_READ,    64, 37,   5,  9, 1'b0, 1, 8'hFF);
      add_row(MODE_INVERT,   0,  0, 127, 63, 1'b0, 1, 8'h00);
      // clipped on both the right edge and the bottom
      add_row(MODE_FILL,   120, 60, 127, 63, 1'b1, 1, 8'hF0);
      add_row(MODE_READ,   127, 56,   0,  0, 1'b0, 1, 8'hF0);
      add_row(MODE_FILL,    10,  3,   5,  2, 1'b1, 1, 8'h38);
      // partial first page, whole middle page, partial last page
      add_row(MODE_FILL,    10,  3,   5, 18, 1'b1, 1, 8'hF8);
      add_row(MODE_READ,    12,  8,   0,  0, 1'b0, 1, 8'hFF);
      add_row(MODE_READ,    15, 16,   0,  0, 1'b0, 1, 8'h3F);
      add_row(MODE_FILL,    10,  8,   0,  7, 1'b0, 1, 8'h00);
      // colour has no effect on invert
      add_row(MODE_INVERT,   8,  0,   7,  7, 1'b1, 1, 8'hFF);
      add_row(MODE_INVERT,   9,  2,   3,  0, 1'b0, 1, 8'hFB);
      add_row(MODE_DOT,      5, 63,   0,  0, 1'b1, 1, 8'h80);
      add_row(MODE_DOT,      5, 63,   0,  0, 1'b0, 1, 8'h00);
      add_row(MODE_FILL,   127,  0,   0,  0, 1'b1, 1, 8'h01);
      add_row(MODE_FILL,     0, 63, 127, 63, 1'b1, 1, 8'h80);
      add_row(MODE_READ,     0,  0,   0,  0, 1'b1, 1, 8'h00);
      add_row(MODE_INVERT,   3,  5, 100, 50, 1'b0, 0, 8'h00);
      add_row(MODE_DOT,     64, 31,   0,  0, 1'b1, 0, 8'h00);
      add_row(MODE_FILL,   100, 13,  30,  9, 1'b0, 0, 8'h00);

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[k])
         send_cmd(directed_rows[k].cmd, directed_rows[k].typed, directed_rows[k].byte_val,
                  1'b0);

      for (i = 0; i < N_RANDOM; i++) begin
         c = random_cmd();
         if (i >= SQUEEZE_FROM && i < SQUEEZE_FROM + SQUEEZE_LEN) begin
            // back-to-back reads while the receiver holds off
            c.mode = MODE_READ;
            send_cmd(c, 1'b0, 8'h00, 1'b1);
         end else begin
            send_cmd(c, 1'b0, 8'h00, ((i / 50) % 4) == 3);
         end
      end
      req_tvalid <= 1'b0;

      while (read_data_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Ran %0d commands: %0d dot, %0d fill, %0d invert, %0d read",
               cmds_taken, mode_cnt[MODE_DOT], mode_cnt[MODE_FILL],
               mode_cnt[MODE_INVERT], mode_cnt[MODE_READ]);
      $display("Checked %0d result bytes, including a %0d-cycle receiver hold-off",
               bytes_checked, HOLD_CYCLES);
      if (err_cnt == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
src/pfrf_pkg.sv
src/pfrf_front.sv
src/pfrf_queue.sv
src/pfrf_back.sv
src/paged_framebuffer_rect_fill_unit.sv
sim/tb_top.sv
